### rtl/etsm_pkg.sv
// etsm_pkg: shared constants, codes and payload types of the event train shift matcher
// no dependencies; imported by event_train_shift_matcher
`default_nettype none

package etsm_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int MAX_SHIFTS  = 64;

	localparam int SAMPLE_AW  = $clog2(MAX_SAMPLES);
	localparam int LEN_W      = SAMPLE_AW + 1;
	localparam int BND_W      = 12;
	localparam int WIN_W      = 10;
	localparam int CNT_W      = 11;
	localparam int SUM_W      = 20;
	localparam int SHIFT_W    = BND_W + 1;
	localparam int P_W        = ((SAMPLE_AW > BND_W) ? SAMPLE_AW : BND_W) + 2;
	localparam int K_W        = (MAX_SHIFTS > 1) ? $clog2(MAX_SHIFTS) : 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = BND_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX   = '1;

	// item function codes
	localparam logic [1:0] FUNC_REF = 2'd0;
	localparam logic [1:0] FUNC_FLO = 2'd1;
	localparam logic [1:0] FUNC_RUN = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic       peak_flag;
	} item_t;

	typedef struct packed {
		logic signed [BND_W-1:0] shift_value;
		logic [CNT_W-1:0]        match_count;
		logic [SUM_W-1:0]        distance_sum;
		logic                    last;
	} result_t;

	// nearest reference peak entry
	typedef struct packed {
		logic                 valid;
		logic [SAMPLE_AW-1:0] idx;
	} near_t;

endpackage

`default_nettype wire

### rtl/etsm_ram.sv
// etsm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module etsm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/event_train_shift_matcher.sv
// event_train_shift_matcher: loads two peak-flag trains, sweeps shifts, scores each shift
// depends on etsm_pkg and etsm_ram
// loads are taken back to back while idle; a run stalls the input through the forward and
// backward build passes (none with an empty reference), then per shift through the scan and a
// 3-stage drain (no scan with an empty floating train) and while a result waits on result_stall
// reset: lengths cleared, left 0, right 0, window 2; memories keep contents, read below length
`default_nettype none

module event_train_shift_matcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire etsm_pkg::item_t                item,
	// results
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output etsm_pkg::result_t                   result,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [etsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [etsm_pkg::CFG_DATA_W-1:0] cfg_data
);

	import etsm_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;  // taking load items
	localparam logic [2:0] ST_FWD    = 3'd1;  // forward pass: nearest peak at or before
	localparam logic [2:0] ST_BWD    = 3'd2;  // backward pass: nearest peak at or after
	localparam logic [2:0] ST_BDRAIN = 3'd3;  // let the last backward write land
	localparam logic [2:0] ST_SCAN   = 3'd4;  // one floating sample per cycle
	localparam logic [2:0] ST_DRAIN  = 3'd5;  // empty the pipe, hand off the result

	logic [2:0] state_q;

	// configuration registers
	logic signed [BND_W-1:0] left_q;
	logic signed [BND_W-1:0] right_q;
	logic [WIN_W-1:0]        window_q;

	// stored train lengths
	logic [LEN_W-1:0] ref_len_q;
	logic [LEN_W-1:0] flo_len_q;

	// sweep counters
	logic [SAMPLE_AW-1:0]      idx_q;      // build pass address
	logic [SAMPLE_AW-1:0]      f_q;        // floating sample address
	logic [K_W-1:0]            k_q;        // shift number within the sweep
	logic [K_W-1:0]            last_k_q;
	logic signed [SHIFT_W-1:0] s_q;        // current shift
	logic [CNT_W-1:0]          count_q;
	logic [SUM_W-1:0]          sum_q;

	// build pipe
	logic                 bld_v_s1;
	logic                 bld_bwd_s1;
	logic [SAMPLE_AW-1:0] bld_idx_s1;
	near_t                fwd_last_q;
	near_t                bwd_last_q;
	near_t                fwd_next;
	near_t                bwd_next;

	// sweep pipe
	logic                  v_s1, v_s2, v_s3;
	logic signed [P_W-1:0] p_s1;
	logic                  neg_s1, over_s1;
	logic                  flag_s2, hasb_s2, hasa_s2;
	logic signed [P_W-1:0] db_s2, da_s2;
	logic                  hit_s3;
	logic [WIN_W-1:0]      d_s3;

	// output register
	logic    result_valid_q;
	result_t result_q;

	// memory ports
	logic                 ref_we, flo_we;
	logic                 ref_rdata, flo_rdata;
	near_t                bef_rdata, aft_rdata;
	logic [SAMPLE_AW-1:0] bef_raddr, aft_raddr;

	// control terms
	logic                    item_acc;
	logic                    ref_full, flo_full;
	logic                    ref_empty, flo_empty;
	logic [LEN_W-1:0]        ref_lenm1, flo_lenm1;
	logic signed [SHIFT_W-1:0] diff;
	logic [K_W-1:0]          last_k_c;
	logic                    out_free, pipe_empty, emit;
	logic signed [P_W-1:0]   p_c;
	logic                    neg_c, over_c;
	logic signed [P_W-1:0]   bidx_x, aidx_x, d_sel;
	logic                    hasb_c, hasa_c, hit_c;
	logic [CNT_W-1:0]        count_inc;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_next;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ref_full  = (ref_len_q == LEN_W'(MAX_SAMPLES));
	assign flo_full  = (flo_len_q == LEN_W'(MAX_SAMPLES));
	assign ref_empty = (ref_len_q == '0);
	assign flo_empty = (flo_len_q == '0);
	assign ref_lenm1 = ref_len_q - 1'b1;
	assign flo_lenm1 = flo_len_q - 1'b1;

	assign ref_we = item_acc && (item.func == FUNC_REF) && !ref_full;
	assign flo_we = item_acc && (item.func == FUNC_FLO) && !flo_full;

	// sweep extent: right clamped to left + MAX_SHIFTS - 1, negative means no shift at all
	assign diff = SHIFT_W'(right_q) - SHIFT_W'(left_q);
	always_comb begin
		if (diff > SHIFT_W'(MAX_SHIFTS - 1)) begin
			last_k_c = K_W'(MAX_SHIFTS - 1);
		end else begin
			last_k_c = diff[K_W-1:0];
		end
	end

	// result hand-off once the last hit has been summed
	assign out_free   = !result_valid_q || !result_stall;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign emit       = (state_q == ST_DRAIN) && pipe_empty && out_free;

	// ---------------------------------------------------------------
	// build pass: running nearest peak, written one entry a cycle
	// ---------------------------------------------------------------
	assign fwd_next = ref_rdata ? near_t'{valid: 1'b1, idx: bld_idx_s1} : fwd_last_q;
	assign bwd_next = ref_rdata ? near_t'{valid: 1'b1, idx: bld_idx_s1} : bwd_last_q;

	// ---------------------------------------------------------------
	// sweep issue: shifted position and the two lookup addresses
	// ---------------------------------------------------------------
	assign p_c    = $signed({{(P_W-SAMPLE_AW){1'b0}}, f_q}) + P_W'(s_q);
	assign neg_c  = p_c[P_W-1];
	assign over_c = !neg_c && (p_c >= $signed({{(P_W-LEN_W){1'b0}}, ref_len_q}));
	// past the end only the last before entry counts, before the start only after[0]
	assign bef_raddr = over_c ? ref_lenm1[SAMPLE_AW-1:0] : p_c[SAMPLE_AW-1:0];
	assign aft_raddr = neg_c ? '0 : p_c[SAMPLE_AW-1:0];

	// stage 1: distances to the peak on each side
	assign bidx_x = $signed({{(P_W-SAMPLE_AW){1'b0}}, bef_rdata.idx});
	assign aidx_x = $signed({{(P_W-SAMPLE_AW){1'b0}}, aft_rdata.idx});
	assign hasb_c = bef_rdata.valid && !neg_s1 && !ref_empty;
	assign hasa_c = aft_rdata.valid && !over_s1 && !ref_empty;

	// stage 2: nearest one and the window test
	always_comb begin
		if (hasb_s2 && (!hasa_s2 || (db_s2 <= da_s2))) begin
			d_sel = db_s2;
		end else begin
			d_sel = da_s2;
		end
	end
	assign hit_c = flag_s2 && (hasb_s2 || hasa_s2)
		&& (d_sel <= $signed({{(P_W-WIN_W){1'b0}}, window_q}));

	// stage 3: saturating accumulate
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign sum_add   = {1'b0, sum_q} + (SUM_W+1)'(d_s3);
	assign sum_next  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			left_q         <= '0;
			right_q        <= '0;
			window_q       <= WIN_W'(2);
			ref_len_q      <= '0;
			flo_len_q      <= '0;
			idx_q          <= '0;
			f_q            <= '0;
			k_q            <= '0;
			last_k_q       <= '0;
			s_q            <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			bld_v_s1       <= 1'b0;
			bld_bwd_s1     <= 1'b0;
			fwd_last_q     <= '0;
			bwd_last_q     <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			hit_s3         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// register writes are to arrive only while idle; the block itself does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LEFT:   left_q   <= $signed(cfg_data[BND_W-1:0]);
					CFG_RIGHT:  right_q  <= $signed(cfg_data[BND_W-1:0]);
					CFG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end

			// build pipe tracking
			bld_v_s1   <= (state_q == ST_FWD) || (state_q == ST_BWD);
			bld_bwd_s1 <= (state_q == ST_BWD);
			if (bld_v_s1 && !bld_bwd_s1) begin
				fwd_last_q <= fwd_next;
			end
			if (bld_v_s1 && bld_bwd_s1) begin
				bwd_last_q <= bwd_next;
			end

			// sweep pipe valids
			v_s1   <= (state_q == ST_SCAN);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			hit_s3 <= v_s2 && hit_c;
			if (v_s3 && hit_s3) begin
				count_q <= count_inc;
				sum_q   <= sum_next;
			end

			// output register
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						unique case (item.func)
							FUNC_REF: begin
								if (!ref_full) ref_len_q <= ref_len_q + 1'b1;
							end
							FUNC_FLO: begin
								if (!flo_full) flo_len_q <= flo_len_q + 1'b1;
							end
							FUNC_RUN: begin
								k_q        <= '0;
								f_q        <= '0;
								idx_q      <= '0;
								s_q        <= SHIFT_W'(left_q);
								last_k_q   <= last_k_c;
								count_q    <= '0;
								sum_q      <= '0;
								fwd_last_q <= '0;
								bwd_last_q <= '0;
								if (diff < 0) begin
									// empty sweep still empties both trains
									ref_len_q <= '0;
									flo_len_q <= '0;
								end else if (ref_empty) begin
									state_q <= flo_empty ? ST_DRAIN : ST_SCAN;
								end else begin
									state_q <= ST_FWD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FWD: begin
					if ({1'b0, idx_q} == ref_lenm1) begin
						state_q <= ST_BWD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BWD: begin
					if (idx_q == '0) begin
						state_q <= ST_BDRAIN;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_BDRAIN: begin
					state_q <= flo_empty ? ST_DRAIN : ST_SCAN;
				end
				ST_SCAN: begin
					if ({1'b0, f_q} == flo_lenm1) begin
						f_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						f_q <= f_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						if (k_q == last_k_q) begin
							ref_len_q <= '0;
							flo_len_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							s_q     <= s_q + 1'b1;
							count_q <= '0;
							sum_q   <= '0;
							state_q <= flo_empty ? ST_DRAIN : ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		bld_idx_s1 <= idx_q;
		p_s1       <= p_c;
		neg_s1     <= neg_c;
		over_s1    <= over_c;
		flag_s2    <= flo_rdata;
		hasb_s2    <= hasb_c;
		hasa_s2    <= hasa_c;
		db_s2      <= p_s1 - bidx_x;
		da_s2      <= aidx_x - p_s1;
		d_s3       <= d_sel[WIN_W-1:0];
		if (emit) begin
			result_q.shift_value  <= s_q[BND_W-1:0];
			result_q.match_count  <= count_q;
			result_q.distance_sum <= sum_q;
			result_q.last         <= (k_q == last_k_q);
		end
	end

	// ---------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------
	// reference flags: appended while idle, read by the build passes
	etsm_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_len_q[SAMPLE_AW-1:0]),
		.wdata (item.peak_flag),
		.raddr (idx_q),
		.rdata (ref_rdata)
	);

	// floating flags: appended while idle, read once per shift
	etsm_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_flo_ram (
		.clk   (clk),
		.we    (flo_we),
		.waddr (flo_len_q[SAMPLE_AW-1:0]),
		.wdata (item.peak_flag),
		.raddr (f_q),
		.rdata (flo_rdata)
	);

	// nearest reference peak at or before each position
	etsm_ram #(.WIDTH($bits(near_t)), .DEPTH(MAX_SAMPLES)) u_bef_ram (
		.clk   (clk),
		.we    (bld_v_s1 && !bld_bwd_s1),
		.waddr (bld_idx_s1),
		.wdata (fwd_next),
		.raddr (bef_raddr),
		.rdata (bef_rdata)
	);

	// nearest reference peak at or after each position
	etsm_ram #(.WIDTH($bits(near_t)), .DEPTH(MAX_SAMPLES)) u_aft_ram (
		.clk   (clk),
		.we    (bld_v_s1 && bld_bwd_s1),
		.waddr (bld_idx_s1),
		.wdata (bwd_next),
		.raddr (aft_raddr),
		.rdata (aft_rdata)
	);

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// a lookup in flight was issued by the scan state
	a_pipe_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q) == ST_SCAN)
		else $error("sweep pipe entry without scan");

	// a new result only appears from a drained shift
	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_DRAIN && $past(pipe_empty))
		else $error("result loaded before the shift drained");

	// scan address never passes the floating length
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !flo_empty && ({1'b0, f_q} <= flo_lenm1))
		else $error("floating address out of range");

	// lengths do not move while a run is under way; this check covers the floating length
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> $stable(flo_len_q))
		else $error("floating length changed during a run");

endmodule

`default_nettype wire
